// File: rtl/risc_single_cycle_core_defines.svh
// Assertion macros shared by the core's RTL.
`ifndef RISC_SINGLE_CYCLE_CORE_DEFINES_SVH
`define RISC_SINGLE_CYCLE_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define RSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rsc assertion failed");

// Next-cycle implication, checked on clk_i outside reset.
`define RSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rsc assertion failed");

`endif

// File: rtl/rsc_pkg.sv
// Types, constants and codes of the single-cycle RISC core.
`default_nettype none

package rsc_pkg;

  localparam int unsigned DMEM_BYTES = 65536;
  localparam int unsigned DMEM_AW    = $clog2(DMEM_BYTES);
  localparam int unsigned NBANK      = 4;
  localparam int unsigned ROW_NUM    = DMEM_BYTES / NBANK;
  localparam int unsigned ROW_AW     = DMEM_AW - 2;
  localparam int unsigned REG_NUM    = 32;
  localparam int unsigned REG_AW     = 5;

  localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_EXEC = 2'd0,
    FUNC_LOAD = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [5:0] {
    OP_RTYPE = 6'd0,
    OP_J     = 6'd2,
    OP_BEQ   = 6'd4,
    OP_ADDIU = 6'd9,
    OP_LW    = 6'd35,
    OP_SW    = 6'd43
  } op_e;

  typedef enum logic [2:0] {
    FN_ADDU = 3'd1,
    FN_SUBU = 3'd3,
    FN_AND  = 3'd4,
    FN_OR   = 3'd5,
    FN_NOR  = 3'd7
  } funct_e;

  // Outcome of executing one item, handed from the execute unit to the top level
  typedef struct packed {
    logic [31:0]                   pc_next;
    logic                          halt_next;
    logic                          reg_we;
    logic [REG_AW-1:0]             reg_idx;
    logic [31:0]                   reg_val;
    logic                          is_lw;
    logic                          is_rd;
    logic                          is_sw;
    logic [1:0]                    lane;
    logic [NBANK-1:0]              bank_we;
    logic [NBANK-1:0][ROW_AW-1:0]  bank_row;
    logic [NBANK-1:0][7:0]         bank_wdata;
  } exec_res_t;

endpackage

`default_nettype wire

// File: rtl/rsc_ram.sv
// Generic one-write, one-read RAM with registered read data.
`default_nettype none

module rsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read returns the old contents when the same address is written in the cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/rsc_exec.sv
// Execute unit: decode, ALU, next pc and data store addressing for one item.
`default_nettype none

module rsc_exec (
  input  wire  rsc_pkg::func_e      func_i,
  input  wire  logic [31:0]         instr_i,
  input  wire  logic [15:0]         mem_addr_i,
  input  wire  logic [7:0]          mem_byte_i,
  input  wire  logic [31:0]         pc_i,
  input  wire  logic                halt_i,
  input  wire  logic [31:0]         op_a_i,
  input  wire  logic [31:0]         op_b_i,
  output rsc_pkg::exec_res_t        res_o
);

  logic [31:0]                  sext;
  logic [31:0]                  pc4;
  logic [31:0]                  ea;
  logic [rsc_pkg::DMEM_AW-1:0]  word_adr;
  logic [rsc_pkg::DMEM_AW-1:0]  byte_adr;
  logic [rsc_pkg::REG_AW-1:0]   rt;
  logic [rsc_pkg::REG_AW-1:0]   rd;
  rsc_pkg::op_e                 op;
  logic                         word_go;
  logic                         is_sw;
  logic                         is_word;
  logic [1:0]                   lane;
  logic [rsc_pkg::NBANK-1:0][rsc_pkg::ROW_AW-1:0] bank_row;
  logic [rsc_pkg::NBANK-1:0][7:0]                 bank_wdata;

  assign sext     = {{16{instr_i[15]}}, instr_i[15:0]};
  assign pc4      = pc_i + 32'd4;
  assign ea       = op_a_i + sext;
  assign word_adr = ea[rsc_pkg::DMEM_AW-1:0];
  assign byte_adr = mem_addr_i[rsc_pkg::DMEM_AW-1:0];
  assign rt       = instr_i[20:16];
  assign rd       = instr_i[15:11];
  assign op       = rsc_pkg::op_e'(instr_i[31:26]);

  // The halt word carries no word-access opcode, so it never counts here
  assign word_go = func_i == rsc_pkg::FUNC_EXEC && !halt_i;
  assign is_sw   = word_go && op == rsc_pkg::OP_SW;
  assign is_word = word_go && (op == rsc_pkg::OP_LW || op == rsc_pkg::OP_SW);

  // Decode and ALU
  always_comb begin
    res_o            = '0;
    res_o.pc_next    = pc_i;
    res_o.halt_next  = halt_i;
    res_o.lane       = lane;
    res_o.bank_row   = bank_row;
    res_o.bank_wdata = bank_wdata;
    if (func_i == rsc_pkg::FUNC_EXEC && !halt_i) begin
      if (instr_i == rsc_pkg::HALT_WORD) begin
        res_o.halt_next = 1'b1;
      end else begin
        res_o.pc_next = pc4;
        unique case (rsc_pkg::op_e'(instr_i[31:26]))
          rsc_pkg::OP_BEQ: begin
            if (op_a_i == op_b_i) begin
              res_o.pc_next = pc4 + {sext[29:0], 2'b00};
            end
          end
          rsc_pkg::OP_J: begin
            res_o.pc_next = {pc4[31:28], instr_i[25:0], 2'b00};
          end
          rsc_pkg::OP_LW: begin
            res_o.is_lw = 1'b1;
            if (rt != '0) begin
              res_o.reg_we  = 1'b1;
              res_o.reg_idx = rt;
            end
          end
          rsc_pkg::OP_SW: begin
            res_o.is_sw   = 1'b1;
            res_o.bank_we = '1;
          end
          rsc_pkg::OP_ADDIU: begin
            if (rt != '0) begin
              res_o.reg_we  = 1'b1;
              res_o.reg_idx = rt;
              res_o.reg_val = ea;
            end
          end
          rsc_pkg::OP_RTYPE: begin
            if (rd != '0) begin
              res_o.reg_we  = 1'b1;
              res_o.reg_idx = rd;
              unique case (rsc_pkg::funct_e'(instr_i[2:0]))
                rsc_pkg::FN_ADDU: res_o.reg_val = op_a_i + op_b_i;
                rsc_pkg::FN_SUBU: res_o.reg_val = op_a_i - op_b_i;
                rsc_pkg::FN_AND:  res_o.reg_val = op_a_i & op_b_i;
                rsc_pkg::FN_OR:   res_o.reg_val = op_a_i | op_b_i;
                rsc_pkg::FN_NOR:  res_o.reg_val = ~(op_a_i | op_b_i);
                default: begin
                  res_o.reg_we  = 1'b0;
                  res_o.reg_idx = '0;
                end
              endcase
            end
          end
          default: ;
        endcase
      end
    end else if (func_i == rsc_pkg::FUNC_LOAD) begin
      res_o.bank_we[byte_adr[1:0]] = 1'b1;
    end else if (func_i == rsc_pkg::FUNC_READ) begin
      res_o.is_rd = 1'b1;
    end
  end

  // Byte lanes: a word at address a puts byte k in bank (a + k) mod 4
  always_comb begin
    logic [1:0]                  k;
    logic [rsc_pkg::DMEM_AW-1:0] adr_k;
    lane = is_word ? word_adr[1:0] : byte_adr[1:0];
    for (int j = 0; j < rsc_pkg::NBANK; j++) begin
      k     = 2'(j) - lane;
      adr_k = word_adr + rsc_pkg::DMEM_AW'(k);
      bank_row[j] = is_word ? adr_k[rsc_pkg::DMEM_AW-1:2]
                            : byte_adr[rsc_pkg::DMEM_AW-1:2];
      if (is_sw) begin
        unique case (k)
          2'd0: bank_wdata[j] = op_b_i[31:24];
          2'd1: bank_wdata[j] = op_b_i[23:16];
          2'd2: bank_wdata[j] = op_b_i[15:8];
          2'd3: bank_wdata[j] = op_b_i[7:0];
        endcase
      end else begin
        bank_wdata[j] = mem_byte_i;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/risc_single_cycle_core.sv
// An accepted item is registered in the execute stage, then in the result stage, from which it leaves.
// Throughput: one item per cycle unless the output stalls; the execute and result stages overlap,
// with register values forwarded from the result stage, loaded words included.
// Reset: the data store is cleared one row of four bytes a cycle, all DMEM_BYTES/4 rows
// (16384 at 65536 bytes), with tready low; registers read zero via valid bits.
`default_nettype none

`include "risc_single_cycle_core_defines.svh"

module risc_single_cycle_core (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [31:0] instr, [47:32] mem_addr, [55:48] mem_byte
  input  wire  logic [55:0] s_axis_tdata_i,
  // [1:0] func
  input  wire  logic [1:0]  s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire  logic        m_axis_tready_i,
  // [31:0] pc_now, [32] halted, [33] reg_written, [38:34] reg_index,
  // [70:39] reg_value, [71] mem_written, [79:72] byte_out
  output logic [79:0]       m_axis_tdata_o
);

  localparam int unsigned AW = rsc_pkg::REG_AW;
  localparam int unsigned RW = rsc_pkg::ROW_AW;

  // Architectural state
  logic [31:0] pc_reg_q;
  logic        halt_q;
  logic [rsc_pkg::REG_NUM-1:0] reg_vld_q;

  // Clearing pass
  logic          clr_busy_q;
  logic [RW-1:0] clr_row_q;

  // Execute stage
  logic            s1_vld_q;
  rsc_pkg::func_e  s1_func_q;
  logic [31:0]     s1_instr_q;
  logic [15:0]     s1_maddr_q;
  logic [7:0]      s1_mbyte_q;
  logic            s1_a_rvld_q, s1_b_rvld_q;
  logic            s1_a_ovr_q, s1_b_ovr_q;
  logic [31:0]     s1_a_val_q, s1_b_val_q;

  // Result stage
  logic          s2_vld_q;
  logic [31:0]   s2_pc_q;
  logic          s2_halt_q;
  logic          s2_we_q;
  logic [AW-1:0] s2_idx_q;
  logic [31:0]   s2_val_q;
  logic          s2_lw_q;
  logic          s2_rd_q;
  logic          s2_mw_q;
  logic [1:0]    s2_lane_q;

  logic          s1_adv;
  logic          accept;
  logic [AW-1:0] rs_in, rt_in, rs_s1, rt_s1;
  logic          wb_en;
  logic [31:0]   wb_val;
  logic [31:0]   rf_a, rf_b;
  logic [31:0]   op_a, op_b;
  logic [31:0]   ld_word;
  logic [7:0]    byte_out;
  logic [rsc_pkg::NBANK-1:0][7:0] bank_rdata;
  rsc_pkg::exec_res_t res;

  assign s1_adv          = s1_vld_q && (!s2_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !clr_busy_q && (!s1_vld_q || s1_adv);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign rs_in = s_axis_tdata_i[25:21];
  assign rt_in = s_axis_tdata_i[20:16];
  assign rs_s1 = s1_instr_q[25:21];
  assign rt_s1 = s1_instr_q[20:16];

  // Write back when the result item leaves
  assign wb_en = s2_vld_q && m_axis_tready_i && s2_we_q;

  // Register file: two copies, one per read port
  rsc_ram #(.WIDTH(32), .DEPTH(rsc_pkg::REG_NUM)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (wb_en),
    .waddr_i (s2_idx_q),
    .wdata_i (wb_val),
    .re_i    (accept),
    .raddr_i (rs_in),
    .rdata_o (rf_a)
  );

  rsc_ram #(.WIDTH(32), .DEPTH(rsc_pkg::REG_NUM)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (wb_en),
    .waddr_i (s2_idx_q),
    .wdata_i (wb_val),
    .re_i    (accept),
    .raddr_i (rt_in),
    .rdata_o (rf_b)
  );

  // Operands: result stage first, then a write caught at capture, then the file
  always_comb begin
    if (s2_vld_q && s2_we_q && s2_idx_q == rs_s1) begin
      op_a = wb_val;
    end else if (s1_a_ovr_q) begin
      op_a = s1_a_val_q;
    end else if (s1_a_rvld_q) begin
      op_a = rf_a;
    end else begin
      op_a = '0;
    end
    if (s2_vld_q && s2_we_q && s2_idx_q == rt_s1) begin
      op_b = wb_val;
    end else if (s1_b_ovr_q) begin
      op_b = s1_b_val_q;
    end else if (s1_b_rvld_q) begin
      op_b = rf_b;
    end else begin
      op_b = '0;
    end
  end

  rsc_exec u_exec (
    .func_i     (s1_func_q),
    .instr_i    (s1_instr_q),
    .mem_addr_i (s1_maddr_q),
    .mem_byte_i (s1_mbyte_q),
    .pc_i       (pc_reg_q),
    .halt_i     (halt_q),
    .op_a_i     (op_a),
    .op_b_i     (op_b),
    .res_o      (res)
  );

  // Data store: four byte banks, row-interleaved
  for (genvar j = 0; j < rsc_pkg::NBANK; j++) begin : g_bank
    rsc_ram #(.WIDTH(8), .DEPTH(rsc_pkg::ROW_NUM)) u_bank (
      .clk_i   (clk_i),
      .we_i    (clr_busy_q || (s1_adv && res.bank_we[j])),
      .waddr_i (clr_busy_q ? clr_row_q : res.bank_row[j]),
      .wdata_i (clr_busy_q ? 8'd0 : res.bank_wdata[j]),
      .re_i    (s1_adv),
      .raddr_i (res.bank_row[j]),
      .rdata_o (bank_rdata[j])
    );
  end

  // Assemble the big-endian word and the single byte from the banks
  always_comb begin
    logic [1:0] bk;
    ld_word = '0;
    for (int k = 0; k < rsc_pkg::NBANK; k++) begin
      bk = s2_lane_q + 2'(k);
      ld_word[8*(3-k) +: 8] = bank_rdata[bk];
    end
  end

  assign byte_out = s2_rd_q ? bank_rdata[s2_lane_q] : 8'd0;
  assign wb_val   = s2_lw_q ? ld_word : s2_val_q;

  assign m_axis_tvalid_o = s2_vld_q;
  assign m_axis_tdata_o  = {byte_out, s2_mw_q, wb_val, s2_idx_q, s2_we_q, s2_halt_q, s2_pc_q};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      pc_reg_q   <= '0;
      halt_q     <= 1'b0;
      reg_vld_q  <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_row_q <= clr_row_q + 1'b1;
        if (clr_row_q == RW'(rsc_pkg::ROW_NUM - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_vld_q <= 1'b1;
        pc_reg_q <= res.pc_next;
        halt_q   <= res.halt_next;
      end else if (m_axis_tready_i) begin
        s2_vld_q <= 1'b0;
      end
      if (wb_en) begin
        reg_vld_q[s2_idx_q] <= 1'b1;
      end
    end
  end

  // Execute stage payload; catch a write-back landing in the same cycle as the read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q   <= rsc_pkg::func_e'(s_axis_tuser_i);
      s1_instr_q  <= s_axis_tdata_i[31:0];
      s1_maddr_q  <= s_axis_tdata_i[47:32];
      s1_mbyte_q  <= s_axis_tdata_i[55:48];
      s1_a_rvld_q <= reg_vld_q[rs_in];
      s1_b_rvld_q <= reg_vld_q[rt_in];
      s1_a_ovr_q  <= wb_en && s2_idx_q == rs_in;
      s1_b_ovr_q  <= wb_en && s2_idx_q == rt_in;
      s1_a_val_q  <= wb_val;
      s1_b_val_q  <= wb_val;
    end
  end

  // Result stage payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_pc_q   <= res.pc_next;
      s2_halt_q <= res.halt_next;
      s2_we_q   <= res.reg_we;
      s2_idx_q  <= res.reg_idx;
      s2_val_q  <= res.reg_val;
      s2_lw_q   <= res.is_lw && res.reg_we;
      s2_rd_q   <= res.is_rd;
      s2_mw_q   <= res.is_sw;
      s2_lane_q <= res.lane;
    end
  end

  `RSC_ASSERT_NXT(a_halt_sticky, halt_q, halt_q)
  `RSC_ASSERT_NXT(a_halt_pc_hold, halt_q, $stable(pc_reg_q))
  `RSC_ASSERT_IMP(a_no_wb_zero, wb_en, s2_idx_q != '0)
  `RSC_ASSERT_NXT(a_clear_once, !clr_busy_q, !clr_busy_q)

endmodule

`default_nettype wire

// File: tb/risc_single_cycle_core_tb.sv
// Self-checking testbench for the single-cycle RISC core with its own prediction of each item.
`default_nettype none

module risc_single_cycle_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WD_LIMIT  = 50000;
  localparam int unsigned RAND_ITEMS = 1400;
  localparam logic [5:0]  OP_UNUSED = 6'h3F;
  localparam logic [2:0]  FN_UNUSED [3] = '{3'd0, 3'd2, 3'd6};

  // One input item with the gap the sender waits before offering it
  typedef struct {
    rsc_pkg::func_e func;
    logic [31:0]    instr;
    logic [15:0]    addr;
    logic [7:0]     mem_byte;
    int unsigned    gap;
  } core_item_t;

  // Laid out so that a cast from the result bus gives the fields in place
  typedef struct packed {
    logic [7:0]  byte_out;
    logic        mem_written;
    logic [31:0] reg_value;
    logic [4:0]  reg_index;
    logic        reg_written;
    logic        halted;
    logic [31:0] pc_now;
  } core_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;

  risc_single_cycle_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  core_item_t  item_q[$];
  core_res_t   retire_q[$];
  int unsigned n_queued;
  int unsigned bad_cnt;
  int unsigned res_cnt;

  // Predicted architectural state
  logic [31:0] pc_st;
  logic        halt_st;
  logic [31:0] gpr [32];
  logic [7:0]  store_mem [rsc_pkg::DMEM_BYTES];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Work out what retiring one item does to the state and what it reports
  function automatic core_res_t retire_item(core_item_t it);
    core_res_t    r;
    rsc_pkg::op_e op;
    logic [4:0]   rs, rt, dst;
    logic [31:0]  sx, a, b, nxt, val, ea, ba, tmp;
    logic         wr_ok;
    r = '0;
    case (it.func)
      rsc_pkg::FUNC_LOAD: store_mem[it.addr % rsc_pkg::DMEM_BYTES] = it.mem_byte;
      rsc_pkg::FUNC_READ: r.byte_out = store_mem[it.addr % rsc_pkg::DMEM_BYTES];
      rsc_pkg::FUNC_EXEC: begin
        if (!halt_st) begin
          if (it.instr == rsc_pkg::HALT_WORD) begin
            halt_st = 1'b1;
          end else begin
            op    = rsc_pkg::op_e'(it.instr[31:26]);
            rs    = it.instr[25:21];
            rt    = it.instr[20:16];
            sx    = {{16{it.instr[15]}}, it.instr[15:0]};
            a     = gpr[rs];
            b     = gpr[rt];
            nxt   = pc_st + 32'd4;
            wr_ok = 1'b0;
            dst   = '0;
            val   = '0;
            ea    = a + sx;
            case (op)
              rsc_pkg::OP_BEQ: begin
                if (a == b) nxt = nxt + (sx << 2);
              end
              rsc_pkg::OP_J: nxt = {nxt[31:28], it.instr[25:0], 2'b00};
              rsc_pkg::OP_LW: begin
                for (int unsigned k = 0; k < 4; k++) begin
                  ba  = ea + k;
                  val = {val[23:0], store_mem[ba % rsc_pkg::DMEM_BYTES]};
                end
                dst   = rt;
                wr_ok = 1'b1;
              end
              rsc_pkg::OP_SW: begin
                for (int unsigned k = 0; k < 4; k++) begin
                  ba  = ea + k;
                  tmp = b >> (24 - 8 * k);
                  store_mem[ba % rsc_pkg::DMEM_BYTES] = tmp[7:0];
                end
                r.mem_written = 1'b1;
              end
              rsc_pkg::OP_ADDIU: begin
                dst   = rt;
                val   = ea;
                wr_ok = 1'b1;
              end
              rsc_pkg::OP_RTYPE: begin
                dst   = it.instr[15:11];
                wr_ok = 1'b1;
                case (it.instr[2:0])
                  rsc_pkg::FN_ADDU: val = a + b;
                  rsc_pkg::FN_SUBU: val = a - b;
                  rsc_pkg::FN_AND:  val = a & b;
                  rsc_pkg::FN_OR:   val = a | b;
                  rsc_pkg::FN_NOR:  val = ~(a | b);
                  default: wr_ok = 1'b0;
                endcase
              end
              default: ;
            endcase
            // drop writes to register zero
            if (wr_ok && dst != 5'd0) begin
              gpr[dst]      = val;
              r.reg_written = 1'b1;
              r.reg_index   = dst;
              r.reg_value   = val;
            end
            pc_st = nxt;
          end
        end
      end
      default: ;
    endcase
    r.pc_now = pc_st;
    r.halted = halt_st;
    return r;
  endfunction

  function automatic logic [31:0] mk_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                       logic [2:0] fn);
    logic [7:0] junk;
    junk = 8'($urandom);
    return {rsc_pkg::OP_RTYPE, rs, rt, rd, junk, fn};
  endfunction

  function automatic logic [31:0] mk_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                       logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Mostly a few low registers so that results feed later instructions
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  // Addresses cluster in a window and at the top of the store to hit earlier writes
  function automatic logic [15:0] win_addr();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 5) return 16'h0100 + 16'($urandom_range(0, 255));
    if (p < 7) return 16'hFFF0 + 16'($urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [4:0]  rs, rt, rd;
    logic [5:0]  op;
    logic [15:0] imm;
    logic [31:0] w;
    int unsigned p;
    rs  = pick_reg();
    rt  = pick_reg();
    rd  = pick_reg();
    imm = 16'($urandom);
    p   = $urandom_range(0, 99);
    if (p < 30) return mk_r(rs, rt, rd, 3'($urandom_range(0, 7)));
    if (p < 50) return mk_i(rsc_pkg::OP_ADDIU, rs, rt, imm);
    if (p < 74) begin
      if ($urandom_range(0, 3) != 0) begin
        rs  = 5'd0;
        imm = win_addr();
      end
      return mk_i((p < 62) ? rsc_pkg::OP_LW : rsc_pkg::OP_SW, rs, rt, imm);
    end
    if (p < 82) return mk_i(rsc_pkg::OP_BEQ, rs, rt, imm);
    if (p < 86) return {rsc_pkg::OP_J, 26'($urandom)};
    if (p < 92) begin
      do op = 6'($urandom);
      while (op == rsc_pkg::OP_RTYPE || op == rsc_pkg::OP_J || op == rsc_pkg::OP_BEQ ||
             op == rsc_pkg::OP_ADDIU || op == rsc_pkg::OP_LW || op == rsc_pkg::OP_SW);
      return {op, 26'($urandom)};
    end
    do w = $urandom;
    while (w == rsc_pkg::HALT_WORD);
    return w;
  endfunction

  task automatic queue_item(rsc_pkg::func_e f, logic [31:0] ins, logic [15:0] ad,
                            logic [7:0] mb);
    core_item_t it;
    it.func     = f;
    it.instr    = ins;
    it.addr     = ad;
    it.mem_byte = mb;
    // every fourth stretch runs back to back
    it.gap      = (((n_queued / 150) % 4) == 3) ? 0 : $urandom_range(0, 7);
    item_q.push_back(it);
    n_queued++;
  endtask

  task automatic queue_exec(logic [31:0] ins);
    queue_item(rsc_pkg::FUNC_EXEC, ins, 16'($urandom), 8'($urandom));
  endtask

  task automatic queue_mem(rsc_pkg::func_e f, logic [15:0] ad, logic [7:0] mb);
    queue_item(f, $urandom, ad, mb);
  endtask

  // Driver: offer items from the queue, predict each one as it is accepted
  core_item_t  cur_item;
  bit          loaded;
  int unsigned wait_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) retire_q.push_back(retire_item(cur_item));
      if (!s_tvalid || s_tready) begin
        if (!loaded && item_q.size() != 0) begin
          cur_item  = item_q.pop_front();
          wait_left = cur_item.gap;
          loaded    = 1'b1;
        end
        if (loaded && wait_left == 0) begin
          s_tvalid <= 1'b1;
          s_tuser  <= cur_item.func;
          s_tdata  <= {cur_item.mem_byte, cur_item.addr, cur_item.instr};
          loaded    = 1'b0;
        end else begin
          if (wait_left > 0) wait_left--;
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, hold off once for a long stretch, check each result
  int unsigned stall_left;
  int unsigned hold_left;

  always @(posedge clk_i or negedge rst_ni) begin
    core_res_t got, want;
    logic      rdy_nxt;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = core_res_t'(m_tdata);
        res_cnt++;
        if (retire_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10) $display("result %0d arrived with nothing expected: %h", res_cnt, got);
        end else begin
          want = retire_q.pop_front();
          if (got !== want) begin
            bad_cnt++;
            if (bad_cnt <= 10) begin
              $write("result %0d exp/got: pc %h/%h halted %b/%b wr %b/%b ", res_cnt,
                     want.pc_now, got.pc_now, want.halted, got.halted,
                     want.reg_written, got.reg_written);
              $display("idx %0d/%0d val %h/%h sw %b/%b byte %h/%h",
                       want.reg_index, got.reg_index, want.reg_value, got.reg_value,
                       want.mem_written, got.mem_written, want.byte_out, got.byte_out);
            end
          end
        end
        stall_left = (((res_cnt / 170) % 4) == 2) ? 0 : $urandom_range(0, 7);
        if (res_cnt == 500) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy_nxt = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy_nxt = 1'b0;
      end else begin
        rdy_nxt = 1'b1;
      end
      m_tready <= rdy_nxt;
    end
  end

  // Watchdog: end the run if nothing moves for too long (covers the store clear)
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WD_LIMIT) begin
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  initial begin
    pc_st   = '0;
    halt_st = 1'b0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (store_mem[i]) store_mem[i] = '0;

    // directed: store extremes, every operation, sign extension, register zero, wrap
    queue_mem(rsc_pkg::FUNC_READ, 16'h0000, 8'($urandom));
    queue_mem(rsc_pkg::FUNC_LOAD, 16'hFFFF, 8'hA5);
    queue_mem(rsc_pkg::FUNC_LOAD, 16'h0000, 8'hFF);
    queue_mem(rsc_pkg::FUNC_READ, 16'hFFFF, 8'($urandom));
    queue_exec(mk_i(rsc_pkg::OP_ADDIU, 5'd0, 5'd1, 16'h7FFF));
    queue_exec(mk_i(rsc_pkg::OP_ADDIU, 5'd0, 5'd2, 16'h8000));
    queue_exec(mk_i(rsc_pkg::OP_ADDIU, 5'd1, 5'd0, 16'h0005));
    queue_exec(mk_r(5'd1, 5'd2, 5'd3, rsc_pkg::FN_ADDU));
    queue_exec(mk_r(5'd0, 5'd1, 5'd4, rsc_pkg::FN_SUBU));
    queue_exec(mk_r(5'd1, 5'd2, 5'd5, rsc_pkg::FN_AND));
    queue_exec(mk_r(5'd1, 5'd2, 5'd6, rsc_pkg::FN_OR));
    queue_exec(mk_r(5'd0, 5'd0, 5'd7, rsc_pkg::FN_NOR));
    foreach (FN_UNUSED[i]) queue_exec(mk_r(5'd1, 5'd1, 5'd8, FN_UNUSED[i]));
    queue_exec(mk_i(rsc_pkg::OP_SW, 5'd0, 5'd7, 16'hFFFE));
    queue_exec(mk_i(rsc_pkg::OP_LW, 5'd0, 5'd8, 16'hFFFE));
    queue_mem(rsc_pkg::FUNC_READ, 16'h0001, 8'($urandom));
    queue_exec(mk_i(rsc_pkg::OP_LW, 5'd0, 5'd0, 16'h0100));
    queue_exec(mk_i(rsc_pkg::OP_BEQ, 5'd1, 5'd1, 16'h0003));
    queue_exec(mk_i(rsc_pkg::OP_BEQ, 5'd1, 5'd2, 16'h0010));
    queue_exec(mk_i(rsc_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000));
    queue_exec({rsc_pkg::OP_J, 26'h3FF_FFFF});
    queue_exec({OP_UNUSED, 26'h0});
    queue_item(rsc_pkg::FUNC_NONE, $urandom, 16'($urandom), 8'($urandom));

    // random program interleaved with store traffic
    repeat (RAND_ITEMS) begin
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 65)      queue_exec(rand_instr());
      else if (p < 80) queue_mem(rsc_pkg::FUNC_LOAD, win_addr(), 8'($urandom));
      else if (p < 95) queue_mem(rsc_pkg::FUNC_READ, win_addr(), 8'($urandom));
      else             queue_item(rsc_pkg::FUNC_NONE, $urandom, 16'($urandom), 8'($urandom));
    end

    // halt, then execute items are ignored while the store stays reachable
    queue_exec(rsc_pkg::HALT_WORD);
    queue_exec(mk_i(rsc_pkg::OP_ADDIU, 5'd0, 5'd1, 16'h1234));
    queue_exec(rsc_pkg::HALT_WORD);
    queue_exec(rand_instr());
    queue_mem(rsc_pkg::FUNC_LOAD, win_addr(), 8'($urandom));
    queue_mem(rsc_pkg::FUNC_READ, win_addr(), 8'($urandom));
    queue_item(rsc_pkg::FUNC_NONE, $urandom, 16'($urandom), 8'($urandom));
    queue_exec(mk_i(rsc_pkg::OP_SW, 5'd0, 5'd7, 16'h0100));
    queue_mem(rsc_pkg::FUNC_READ, 16'h0100, 8'($urandom));

    @(posedge rst_ni);
    while (item_q.size() != 0 || loaded || s_tvalid || retire_q.size() != 0)
      @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (bad_cnt == 0 && retire_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
